>>> hw/rtl/hti_pkg.sv
// ----------------------------------------------------------------------------
// hti_pkg: shared types and constants of the hash table unit
// Opcodes, status codes, sequencer states and the store control bundle.
// ----------------------------------------------------------------------------
package hti_pkg;

    // multiplicative hash constant (golden ratio of 2^32)
    localparam logic [31:0] HASH_MULT = 32'd2654435769;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_INSERT = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_MISS = 2'd1,
        STATUS_FULL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HOME,
        ST_READ,
        ST_CHECK
    } state_t;

    // write controls from the sequencer to the slot store
    typedef struct packed {
        logic clear;    // write key zero at the address
        logic wr_key;   // write the item key at the address
        logic wr_refs;  // write handler and context references
    } store_ctl_t;

endpackage

>>> hw/rtl/hti_hash.sv
// ----------------------------------------------------------------------------
// hti_hash: home slot of a key
// Registers the low 32 bits of key times the hash constant and takes the top
// floor(log2(SLOTS)) bits as the home slot.
// ----------------------------------------------------------------------------
module hti_hash
    import hti_pkg::*;
#(
    parameter int SLOTS = 64
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [15:0]                key,
    output logic [$clog2(SLOTS)-1:0]   home
);

    localparam int AW    = $clog2(SLOTS);
    localparam int IDX_W = $clog2(SLOTS + 1) - 1;

    logic [31:0] prod_reg;
    logic [31:0] prod_next;

    // keep the low word of the product
    assign prod_next = {16'd0, key} * HASH_MULT;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    // top bits of the product, always below SLOTS
    assign home = AW'(prod_reg[31 -: IDX_W]);

endmodule

>>> hw/rtl/hti_store.sv
// ----------------------------------------------------------------------------
// hti_store: slot memories
// Key, handler and context arrays with one write and one registered read
// at a shared address.
// ----------------------------------------------------------------------------
module hti_store
    import hti_pkg::*;
#(
    parameter int SLOTS = 64
) (
    input  logic                       clk,
    input  logic [$clog2(SLOTS)-1:0]   addr,
    input  store_ctl_t                 ctl,
    input  logic [15:0]                key_in,
    input  logic [31:0]                href_in,
    input  logic [31:0]                cref_in,
    output logic [15:0]                rd_key,
    output logic [31:0]                rd_href,
    output logic [31:0]                rd_cref
);

    logic [15:0] key_mem  [SLOTS];
    logic [31:0] href_mem [SLOTS];
    logic [31:0] cref_mem [SLOTS];

    logic [15:0] rd_key_reg;
    logic [31:0] rd_href_reg;
    logic [31:0] rd_cref_reg;

    // write key store: clear or item key
    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            key_mem[addr] <= 16'd0;
        end
        else if (ctl.wr_key)
        begin
            key_mem[addr] <= key_in;
        end
    end

    // write reference stores
    always_ff @(posedge clk)
    begin
        if (ctl.wr_refs)
        begin
            href_mem[addr] <= href_in;
            cref_mem[addr] <= cref_in;
        end
    end

    // read all three arrays every cycle
    always_ff @(posedge clk)
    begin
        rd_key_reg  <= key_mem[addr];
        rd_href_reg <= href_mem[addr];
        rd_cref_reg <= cref_mem[addr];
    end

    assign rd_key  = rd_key_reg;
    assign rd_href = rd_href_reg;
    assign rd_cref = rd_cref_reg;

endmodule

>>> hw/rtl/hti_ctrl.sv
// ----------------------------------------------------------------------------
// hti_ctrl: probe sequencer
// Clears the key store after reset, then walks slots from the home slot one
// probe at a time with a single key compare, and issues the result item.
// ----------------------------------------------------------------------------
module hti_ctrl
    import hti_pkg::*;
#(
    parameter int SLOTS = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       opcode,
    input  logic [15:0]                key,
    input  logic [31:0]                handler_ref,
    input  logic [31:0]                context_ref,
    input  logic [$clog2(SLOTS)-1:0]   home,
    input  logic [15:0]                rd_key,
    input  logic [31:0]                rd_href,
    input  logic [31:0]                rd_cref,
    output logic                       busy,
    output logic                       hash_en,
    output logic [$clog2(SLOTS)-1:0]   addr,
    output store_ctl_t                 ctl,
    output logic [15:0]                key_held,
    output logic [31:0]                href_held,
    output logic [31:0]                cref_held,
    output logic                       done,
    output logic [1:0]                 status,
    output logic [31:0]                handler_out,
    output logic [31:0]                context_out
);

    localparam int AW = $clog2(SLOTS);
    localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

    state_t         state_reg, state_next;
    logic [AW-1:0]  addr_reg, addr_next;
    logic [AW-1:0]  cnt_reg, cnt_next;
    op_t            op_reg, op_next;
    logic [15:0]    key_reg, key_next;
    logic [31:0]    href_reg, href_next;
    logic [31:0]    cref_reg, cref_next;
    logic           done_reg, done_next;
    status_t        status_reg, status_next;
    logic [31:0]    hout_reg, hout_next;
    logic [31:0]    cout_reg, cout_next;

    logic accept;
    logic hit;
    logic empty;
    logic last_probe;

    assign accept     = start && (state_reg == ST_IDLE);
    assign hit        = (rd_key == key_reg);
    assign empty      = (rd_key == 16'd0);
    assign last_probe = (cnt_reg == LAST_SLOT);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (addr_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start && key != 16'd0)
                begin
                    state_next = ST_HOME;
                end
            end
            ST_HOME:
            begin
                state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (op_reg == OP_INSERT)
                begin
                    state_next = (hit || empty || last_probe) ? ST_IDLE : ST_READ;
                end
                else
                begin
                    state_next = (hit || empty || last_probe) ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and store controls
    always_comb
    begin
        addr_next   = addr_reg;
        cnt_next    = cnt_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        href_next   = href_reg;
        cref_next   = cref_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        hout_next   = hout_reg;
        cout_next   = cout_reg;
        ctl         = '0;
        hash_en     = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ctl.clear = 1'b1;
                addr_next = (addr_reg == LAST_SLOT) ? '0 : addr_reg + AW'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    hash_en   = 1'b1;
                    op_next   = op_t'(opcode);
                    key_next  = key;
                    href_next = handler_ref;
                    cref_next = context_ref;
                    if (key == 16'd0)
                    begin
                        // empty marker: answer at once, touch nothing
                        done_next   = 1'b1;
                        status_next = (op_t'(opcode) == OP_INSERT) ? STATUS_OK : STATUS_MISS;
                        hout_next   = 32'd0;
                        cout_next   = 32'd0;
                    end
                end
            end
            ST_HOME:
            begin
                addr_next = home;
                cnt_next  = '0;
            end
            ST_READ:
            begin
            end
            ST_CHECK:
            begin
                hout_next = 32'd0;
                cout_next = 32'd0;
                if (op_reg == OP_INSERT)
                begin
                    if (hit || empty)
                    begin
                        ctl.wr_key  = 1'b1;
                        ctl.wr_refs = 1'b1;
                        done_next   = 1'b1;
                        status_next = STATUS_OK;
                    end
                    else if (last_probe)
                    begin
                        done_next   = 1'b1;
                        status_next = STATUS_FULL;
                    end
                end
                else
                begin
                    if (empty)
                    begin
                        done_next   = 1'b1;
                        status_next = STATUS_MISS;
                    end
                    else if (hit)
                    begin
                        done_next   = 1'b1;
                        status_next = STATUS_OK;
                        hout_next   = rd_href;
                        cout_next   = rd_cref;
                    end
                    else if (last_probe)
                    begin
                        done_next   = 1'b1;
                        status_next = STATUS_MISS;
                    end
                end
                // advance to the next slot, wrapping at the end
                if (!done_next)
                begin
                    addr_next = (addr_reg == LAST_SLOT) ? '0 : addr_reg + AW'(1);
                    cnt_next  = cnt_reg + AW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            addr_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        op_reg     <= op_next;
        key_reg    <= key_next;
        href_reg   <= href_next;
        cref_reg   <= cref_next;
        status_reg <= status_next;
        hout_reg   <= hout_next;
        cout_reg   <= cout_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign addr        = addr_reg;
    assign key_held    = key_reg;
    assign href_held   = href_reg;
    assign cref_held   = cref_reg;
    assign done        = done_reg;
    assign status      = status_reg;
    assign handler_out = hout_reg;
    assign context_out = cout_reg;

    // a result item follows only a final probe or a key-zero item
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_CHECK ||
                           (state_reg == ST_IDLE && start && key == 16'd0)))
        else $error("result item without a finished probe");

    // references are only written by an insert
    a_wr_insert: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wr_refs |-> (state_reg == ST_CHECK && op_reg == OP_INSERT))
        else $error("reference write outside an insert");

    // a lookup that reaches an empty slot reports a miss
    a_empty_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && op_reg == OP_LOOKUP && rd_key == 16'd0)
        |=> (done_reg && status_reg == STATUS_MISS))
        else $error("lookup past an empty slot");

    // no new item is taken while the key store is cleared
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (busy && ctl.clear && !ctl.wr_refs))
        else $error("clearing pass not exclusive");

endmodule

>>> hw/rtl/hash_table_insert_lookup_unit.sv
// ----------------------------------------------------------------------------
// hash_table_insert_lookup_unit: keyed slot table with linear probing
// Insert or look up 16-bit keys with handler and context references.
// ----------------------------------------------------------------------------
// After reset the unit holds busy while it clears the key store, one slot
// per cycle. An item is taken when start is high and busy is low. A key of
// zero is answered in the cycle after it is taken; any other item forms
// its home slot in the hash register and the HOME state, then probes slot
// by slot, each probe a registered memory read and then a key compare, up
// to a full pass over all slots. The result item shows on status,
// handler_out and context_out for one cycle with done high and cannot be
// held off; busy is low again in that cycle, so the next item may start.
// ----------------------------------------------------------------------------
module hash_table_insert_lookup_unit
    import hti_pkg::*;
#(
    parameter int SLOTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic [15:0] key,
    input  logic [31:0] handler_ref,
    input  logic [31:0] context_ref,
    output logic        done,
    output logic [1:0]  status,
    output logic [31:0] handler_out,
    output logic [31:0] context_out
);

    localparam int AW = $clog2(SLOTS);

    logic            hash_en;
    logic [AW-1:0]   home;
    logic [AW-1:0]   addr;
    store_ctl_t      ctl;
    logic [15:0]     key_held;
    logic [31:0]     href_held;
    logic [31:0]     cref_held;
    logic [15:0]     rd_key;
    logic [31:0]     rd_href;
    logic [31:0]     rd_cref;

    // home slot multiplier
    hti_hash #(.SLOTS(SLOTS)) u_hash (
        .clk  (clk),
        .en   (hash_en),
        .key  (key),
        .home (home)
    );

    // slot memories
    hti_store #(.SLOTS(SLOTS)) u_store (
        .clk     (clk),
        .addr    (addr),
        .ctl     (ctl),
        .key_in  (key_held),
        .href_in (href_held),
        .cref_in (cref_held),
        .rd_key  (rd_key),
        .rd_href (rd_href),
        .rd_cref (rd_cref)
    );

    // probe sequencer
    hti_ctrl #(.SLOTS(SLOTS)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .opcode      (opcode),
        .key         (key),
        .handler_ref (handler_ref),
        .context_ref (context_ref),
        .home        (home),
        .rd_key      (rd_key),
        .rd_href     (rd_href),
        .rd_cref     (rd_cref),
        .busy        (busy),
        .hash_en     (hash_en),
        .addr        (addr),
        .ctl         (ctl),
        .key_held    (key_held),
        .href_held   (href_held),
        .cref_held   (cref_held),
        .done        (done),
        .status      (status),
        .handler_out (handler_out),
        .context_out (context_out)
    );

endmodule

>>> tb/tb_hash_table_insert_lookup_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hash_table_insert_lookup_unit: self-checking bench of the slot table
// Drives insert and lookup items, starting with a table of directed cases:
// key zero, extreme keys and references, updates, probe chains and a chain
// that wraps past the last slot. Random items on a small key set follow.
// The last phase fills every slot, then checks the full-table answers.
// A local copy of the table predicts each result item, unless the item
// carries its own; results are compared in order, field by field.
// ----------------------------------------------------------------------------
module tb_hash_table_insert_lookup_unit
    import hti_pkg::*;
();

    localparam int SLOTS        = 64;
    localparam int IDX_BITS     = $clog2(SLOTS);
    localparam int KEY_POOL     = 48;
    localparam int RANDOM_ITEMS = 900;
    localparam int FULL_ITEMS   = 100;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 16;

    typedef struct packed {
        status_t     status;
        logic [31:0] href;
        logic [31:0] cref;
    } hash_result_t;

    typedef struct packed {
        op_t          op;
        logic [15:0]  key;
        logic [31:0]  href;
        logic [31:0]  cref;
        logic         typed;
        hash_result_t want;
    } table_op_t;

    localparam hash_result_t R_OK     = '{STATUS_OK, 32'h0, 32'h0};
    localparam hash_result_t R_MISS   = '{STATUS_MISS, 32'h0, 32'h0};
    localparam hash_result_t R_FULL   = '{STATUS_FULL, 32'h0, 32'h0};
    localparam hash_result_t NO_CHECK = '0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        opcode = 1'b0;
    logic [15:0] key = 16'h0;
    logic [31:0] handler_ref = 32'h0;
    logic [31:0] context_ref = 32'h0;
    logic        busy;
    logic        done;
    logic [1:0]  status;
    logic [31:0] handler_out;
    logic [31:0] context_out;

    // local copy of the slot store
    logic [15:0] tbl_key  [SLOTS];
    logic [31:0] tbl_href [SLOTS];
    logic [31:0] tbl_cref [SLOTS];

    hash_result_t expected_results [$];
    table_op_t    directed_ops [24];
    int           mismatch_count = 0;
    bit           idle_on = 1'b1;

    hash_table_insert_lookup_unit #(
        .SLOTS(SLOTS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .opcode(opcode),
        .key(key),
        .handler_ref(handler_ref),
        .context_ref(context_ref),
        .done(done),
        .status(status),
        .handler_out(handler_out),
        .context_out(context_out)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // home slot: top index bits of the low word of key times the hash constant
    function automatic int home_of(logic [15:0] k);
        logic [31:0] prod;
        prod = {16'h0, k} * HASH_MULT;
        return int'(prod >> (32 - IDX_BITS)) % SLOTS;
    endfunction

    // apply one item to the local table and return its result item
    function automatic hash_result_t predict_table(table_op_t it);
        hash_result_t res;
        int           slot;
        int           i;
        res = R_MISS;
        if (it.op == OP_INSERT)
        begin
            res = (it.key == 16'h0) ? R_OK : R_FULL;
            if (it.key != 16'h0)
            begin
                for (i = 0; i < SLOTS; i++)
                begin
                    slot = (home_of(it.key) + i) % SLOTS;
                    if (tbl_key[slot] == 16'h0 || tbl_key[slot] == it.key)
                    begin
                        tbl_key[slot]  = it.key;
                        tbl_href[slot] = it.href;
                        tbl_cref[slot] = it.cref;
                        res = R_OK;
                        break;
                    end
                end
            end
        end
        else if (it.key != 16'h0)
        begin
            for (i = 0; i < SLOTS; i++)
            begin
                slot = (home_of(it.key) + i) % SLOTS;
                if (tbl_key[slot] == 16'h0)
                    break;
                if (tbl_key[slot] == it.key)
                begin
                    res = '{STATUS_OK, tbl_href[slot], tbl_cref[slot]};
                    break;
                end
            end
        end
        return res;
    endfunction

    function automatic int occupied_slots();
        int cnt;
        cnt = 0;
        foreach (tbl_key[i])
            if (tbl_key[i] != 16'h0)
                cnt++;
        return cnt;
    endfunction

    // nonzero key that the table does not hold
    function automatic logic [15:0] fresh_key();
        logic [15:0] k;
        bit          held;
        do
        begin
            k = 16'($urandom_range(1, 65535));
            held = 1'b0;
            foreach (tbl_key[i])
                if (tbl_key[i] == k)
                    held = 1'b1;
        end
        while (held);
        return k;
    endfunction

    // present one item, hold it until taken, then record its expected result
    task automatic issue(input table_op_t it, input bit drain);
        int           gap;
        hash_result_t res;
        gap = idle_on ? $urandom_range(0, 14) : 0;
        if (gap > 0 || drain)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
            if (drain)
            begin
                do
                    @(posedge clk);
                while (expected_results.size() != 0);
            end
        end
        start       <= 1'b1;
        opcode      <= it.op;
        key         <= it.key;
        handler_ref <= it.href;
        context_ref <= it.cref;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        res = predict_table(it);
        if (it.typed)
            res = it.want;
        expected_results.push_back(res);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // compare each result item with the oldest expectation
    always @(posedge clk)
    begin : result_check
        hash_result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0d %h %h",
                         $time, status, handler_out, context_out);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("status", 32'(want.status), 32'(status));
                check_field("handler_out", want.href, handler_out);
                check_field("context_out", want.cref, context_out);
            end
        end
    end

    initial
    begin : stimulus
        table_op_t   it;
        logic [15:0] pool [KEY_POOL];
        int          anchor;
        int          pick;
        int          n;

        foreach (tbl_key[i])
            tbl_key[i] = 16'h0;

        // keys 1, 90, 145, 234 share one home slot; 55, 144, 199 share the
        // last slot and wrap to the first ones
        directed_ops = '{
            '{OP_LOOKUP, 16'h0000, 32'h0, 32'h0, 1'b1, R_MISS},
            '{OP_LOOKUP, 16'hFFFF, 32'h0, 32'h0, 1'b1, R_MISS},
            '{OP_INSERT, 16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, R_OK},
            '{OP_LOOKUP, 16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, R_MISS},
            '{OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 1'b1, R_OK},
            '{OP_LOOKUP, 16'hFFFF, 32'h0, 32'h0, 1'b1,
              '{STATUS_OK, 32'hFFFF_FFFF, 32'h0}},
            '{OP_INSERT, 16'd1, 32'h0, 32'hFFFF_FFFF, 1'b1, R_OK},
            '{OP_INSERT, 16'd90, 32'h1111_1111, 32'h2222_2222, 1'b1, R_OK},
            '{OP_INSERT, 16'd145, 32'h3333_3333, 32'h4444_4444, 1'b1, R_OK},
            '{OP_INSERT, 16'd234, 32'h5555_5555, 32'h6666_6666, 1'b1, R_OK},
            '{OP_LOOKUP, 16'd234, 32'h0, 32'h0, 1'b0, NO_CHECK},
            '{OP_LOOKUP, 16'd179, 32'h0, 32'h0, 1'b0, NO_CHECK},
            '{OP_INSERT, 16'd1, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b1, R_OK},
            '{OP_LOOKUP, 16'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
              '{STATUS_OK, 32'hA5A5_A5A5, 32'h5A5A_5A5A}},
            '{OP_LOOKUP, 16'd90, 32'h0, 32'h0, 1'b0, NO_CHECK},
            '{OP_INSERT, 16'd55, 32'h0000_0001, 32'h8000_0000, 1'b1, R_OK},
            '{OP_INSERT, 16'd144, 32'h7777_7777, 32'h8888_8888, 1'b1, R_OK},
            '{OP_INSERT, 16'd199, 32'h9999_9999, 32'hAAAA_AAAA, 1'b1, R_OK},
            '{OP_LOOKUP, 16'd199, 32'h0, 32'h0, 1'b0, NO_CHECK},
            '{OP_LOOKUP, 16'd144, 32'h0, 32'h0, 1'b0, NO_CHECK},
            '{OP_LOOKUP, 16'd55, 32'h0, 32'h0, 1'b0, NO_CHECK},
            '{OP_INSERT, 16'h8000, 32'h8000_0000, 32'h0000_0001, 1'b1, R_OK},
            '{OP_LOOKUP, 16'h8000, 32'h0, 32'h0, 1'b0, NO_CHECK},
            '{OP_LOOKUP, 16'h7FFF, 32'h0, 32'h0, 1'b0, NO_CHECK}
        };

        // key set for the random phase: four clusters of six colliding keys,
        // the rest spread at random; stays well below the slot count
        for (n = 0; n < KEY_POOL; n++)
        begin
            if (n % 6 == 0 || n >= 24)
            begin
                pool[n] = 16'($urandom_range(1, 65535));
                anchor = home_of(pool[n]);
            end
            else
            begin
                do
                    pool[n] = 16'($urandom_range(1, 65535));
                while (home_of(pool[n]) != anchor);
            end
        end

        // hold reset, then release
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // walk the directed table
        foreach (directed_ops[i])
            issue(directed_ops[i], 1'b0);

        // random items on the key set, idling switched on and off in stretches
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 64 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            it = '0;
            it.href = $urandom;
            it.cref = $urandom;
            if (pick < 45)
            begin
                it.op  = OP_INSERT;
                it.key = pool[$urandom_range(0, KEY_POOL - 1)];
            end
            else if (pick < 80)
            begin
                it.op  = OP_LOOKUP;
                it.key = pool[$urandom_range(0, KEY_POOL - 1)];
            end
            else if (pick < 95)
            begin
                it.op  = OP_LOOKUP;
                it.key = 16'($urandom_range(0, 65535));
            end
            else
            begin
                it.op  = op_t'($urandom_range(0, 1));
                it.key = 16'h0;
            end
            issue(it, $urandom_range(0, 99) == 0);
        end

        // fill every slot; wait for the table to go quiet first
        idle_on = 1'b1;
        n = 0;
        while (occupied_slots() < SLOTS)
        begin
            it = '{OP_INSERT, fresh_key(), $urandom, $urandom, 1'b1, R_OK};
            issue(it, n == 0);
            n++;
        end

        // full table: new keys are refused, absent keys take a full pass
        for (n = 0; n < 4; n++)
        begin
            issue('{OP_INSERT, fresh_key(), $urandom, $urandom, 1'b1, R_FULL}, 1'b0);
            issue('{OP_LOOKUP, fresh_key(), $urandom, $urandom, 1'b1, R_MISS}, 1'b0);
        end

        // random items on the full table
        for (n = 0; n < FULL_ITEMS; n++)
        begin
            if (n % 32 == 0)
                idle_on = ($urandom_range(0, 1) != 0);
            pick = $urandom_range(0, 99);
            it = '0;
            it.href = $urandom;
            it.cref = $urandom;
            it.op   = op_t'($urandom_range(0, 1));
            if (pick < 60)
                it.key = tbl_key[$urandom_range(0, SLOTS - 1)];
            else if (pick < 90)
                it.key = fresh_key();
            else
                it.key = 16'h0;
            issue(it, 1'b0);
        end
        start <= 1'b0;

        // let the last results arrive
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("[hash_table_insert_lookup_unit] OK");
        else
            $display("[hash_table_insert_lookup_unit] ERROR");
        $finish;
    end

    // abort a hung run
    initial
    begin : watchdog
        #(64'd20_000_000);
        $display("[hash_table_insert_lookup_unit] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/hti_pkg.sv
hw/rtl/hti_hash.sv
hw/rtl/hti_store.sv
hw/rtl/hti_ctrl.sv
hw/rtl/hash_table_insert_lookup_unit.sv
tb/tb_hash_table_insert_lookup_unit.sv
